// ----- rtl/cp2r_pkg.sv -----
// ----------------------------------------------------------------------------
// cp2r_pkg
// shared types and fixed-point constants for the polar-to-rectangular cordic
// ----------------------------------------------------------------------------
package cp2r_pkg;

    localparam int ROTATION_STEPS = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int NUM_STEPS      = (ROTATION_STEPS < ATAN_ENTRIES) ?
                                    ROTATION_STEPS : ATAN_ENTRIES;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 31;
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int XY_W        = 36;
    localparam int Z_W         = 36;
    localparam int ATAN_W      = 30;
    localparam int ANGLE_SHIFT = 17;
    localparam int X0_SHIFT    = 14;
    localparam int OUT_SHIFT   = 16;
    localparam int XQ_W        = XY_W - OUT_SHIFT;

    // cordic gain compensation, 0.60725293500888 in units of 2^-30
    localparam logic signed [GAIN_W-1:0] KGAIN      = 31'sd652032874;
    // angles in units of 2^-30 rad
    localparam logic signed [Z_W-1:0]    PI_FX      = 36'sd3373259426;
    localparam logic signed [Z_W-1:0]    TWO_PI_FX  = 36'sd6746518852;
    localparam logic signed [Z_W-1:0]    HALF_PI_FX = 36'sd1686629713;

    localparam logic signed [PROD_W-1:0] X0_ROUND  = 47'sd8192;
    localparam logic signed [XY_W-1:0]   OUT_ROUND = 36'sd32768;

    localparam logic signed [XQ_W-1:0]   SAT_MAX = 20'sd32767;
    localparam logic signed [XQ_W-1:0]   SAT_MIN = -20'sd32768;

    // atan(2^-i) in units of 2^-30 rad
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic                   rect;
        logic                   flip;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        sample_t                a;
        sample_t                b;
    } cordic_t;

endpackage

// ----- rtl/cp2r_prep.sv -----
// ----------------------------------------------------------------------------
// cp2r_prep
// two-stage front end: gain-scaled magnitude and angle range reduction
// ----------------------------------------------------------------------------
module cp2r_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_rect,
    input  cp2r_pkg::sample_t in_a,
    input  cp2r_pkg::sample_t in_b,
    output logic              out_valid,
    input  logic              out_ready,
    output cp2r_pkg::cordic_t out_data
);
    import cp2r_pkg::*;

    // stage a: multiply and 2 pi wrap
    logic                     va_reg;
    logic                     rect_a_reg;
    sample_t                  a_a_reg;
    sample_t                  b_a_reg;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_a_next;
    logic signed [Z_W-1:0]    z_a_reg;
    logic signed [Z_W-1:0]    z_a_next;
    logic signed [Z_W-1:0]    z_raw;

    // stage b: quarter-turn fold and rounded start vector
    logic                     vb_reg;
    cordic_t                  d_b_reg;
    cordic_t                  d_b_next;

    logic                     rdy_a;
    logic                     rdy_b;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        prod_a_next = PROD_W'(in_a) * PROD_W'(KGAIN);
        z_raw       = Z_W'(in_b) <<< ANGLE_SHIFT;
        priority if (z_raw > PI_FX)
        begin
            z_a_next = z_raw - TWO_PI_FX;
        end
        else if (z_raw < -PI_FX)
        begin
            z_a_next = z_raw + TWO_PI_FX;
        end
        else
        begin
            z_a_next = z_raw;
        end
    end

    always_comb
    begin
        d_b_next.rect = rect_a_reg;
        d_b_next.a    = a_a_reg;
        d_b_next.b    = b_a_reg;
        d_b_next.x    = XY_W'((prod_a_reg + X0_ROUND) >>> X0_SHIFT);
        d_b_next.y    = '0;
        priority if (z_a_reg > HALF_PI_FX)
        begin
            d_b_next.z    = z_a_reg - PI_FX;
            d_b_next.flip = 1'b1;
        end
        else if (z_a_reg < -HALF_PI_FX)
        begin
            d_b_next.z    = z_a_reg + PI_FX;
            d_b_next.flip = 1'b1;
        end
        else
        begin
            d_b_next.z    = z_a_reg;
            d_b_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            rect_a_reg <= in_rect;
            a_a_reg    <= in_a;
            b_a_reg    <= in_b;
            prod_a_reg <= prod_a_next;
            z_a_reg    <= z_a_next;
        end
        if (rdy_b && va_reg)
        begin
            d_b_reg <= d_b_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = d_b_reg;

endmodule

// ----- rtl/cp2r_cordic.sv -----
// ----------------------------------------------------------------------------
// cp2r_cordic
// unrolled rotation-mode cordic, one register stage per micro-rotation
// ----------------------------------------------------------------------------
module cp2r_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cp2r_pkg::cordic_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cp2r_pkg::cordic_t out_data
);
    import cp2r_pkg::*;

    logic    v_reg   [NUM_STEPS];
    cordic_t d_reg   [NUM_STEPS];
    cordic_t d_next  [NUM_STEPS];
    logic    v_src   [NUM_STEPS];
    cordic_t d_src   [NUM_STEPS];
    logic    rdy     [NUM_STEPS+1];

    assign rdy[NUM_STEPS] = out_ready;
    assign in_ready       = rdy[0];
    assign out_valid      = v_reg[NUM_STEPS-1];
    assign out_data       = d_reg[NUM_STEPS-1];

    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_step
        logic signed [XY_W-1:0] x_sh;
        logic signed [XY_W-1:0] y_sh;
        logic signed [Z_W-1:0]  ang;

        if (k == 0)
        begin : g_first
            assign v_src[k] = in_valid;
            assign d_src[k] = in_data;
        end
        else
        begin : g_next
            assign v_src[k] = v_reg[k-1];
            assign d_src[k] = d_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            x_sh      = d_src[k].x >>> k;
            y_sh      = d_src[k].y >>> k;
            ang       = Z_W'(ATAN_TAB[k]);
            d_next[k] = d_src[k];
            if (!d_src[k].z[Z_W-1])
            begin
                d_next[k].x = d_src[k].x - y_sh;
                d_next[k].y = d_src[k].y + x_sh;
                d_next[k].z = d_src[k].z - ang;
            end
            else
            begin
                d_next[k].x = d_src[k].x + y_sh;
                d_next[k].y = d_src[k].y - x_sh;
                d_next[k].z = d_src[k].z + ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= v_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && v_src[k])
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

endmodule

// ----- rtl/cp2r_post.sv -----
// ----------------------------------------------------------------------------
// cp2r_post
// half-turn sign fix, rounding to q1.14, saturation and output register; rectangular inputs pass through
// ----------------------------------------------------------------------------
module cp2r_post (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cp2r_pkg::cordic_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cp2r_pkg::sample_t out_real,
    output cp2r_pkg::sample_t out_imag
);
    import cp2r_pkg::*;

    logic                   v_reg;
    sample_t                re_reg;
    sample_t                re_next;
    sample_t                im_reg;
    sample_t                im_next;
    logic signed [XY_W-1:0] xr;
    logic signed [XY_W-1:0] yr;
    logic signed [XQ_W-1:0] xq;
    logic signed [XQ_W-1:0] yq;

    function automatic sample_t sat16(input logic signed [XQ_W-1:0] v);
        sample_t r;
        priority if (v > SAT_MAX)
        begin
            r = SAMPLE_W'(SAT_MAX);
        end
        else if (v < SAT_MIN)
        begin
            r = SAMPLE_W'(SAT_MIN);
        end
        else
        begin
            r = SAMPLE_W'(v);
        end
        return r;
    endfunction

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        // negate and round in one add: -x + half = half - x
        xr = in_data.flip ? (OUT_ROUND - in_data.x) : (in_data.x + OUT_ROUND);
        yr = in_data.flip ? (OUT_ROUND - in_data.y) : (in_data.y + OUT_ROUND);
        xq = XQ_W'(xr >>> OUT_SHIFT);
        yq = XQ_W'(yr >>> OUT_SHIFT);
        if (in_data.rect)
        begin
            re_next = in_data.a;
            im_next = in_data.b;
        end
        else
        begin
            re_next = sat16(xq);
            im_next = sat16(yq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    assign out_valid = v_reg;
    assign out_real  = re_reg;
    assign out_imag  = im_reg;

endmodule

// ----- rtl/complex_polar_to_rect_unit.sv -----
// ----------------------------------------------------------------------------
// complex_polar_to_rect_unit
// streaming polar-to-rectangular converter built on a pipelined cordic
// ----------------------------------------------------------------------------
// usage:
//   slave channel carries one complex number per transfer; tuser[0] set means
//   the two values already are real and imaginary parts and pass unchanged,
//   clear means tdata holds a q1.14 magnitude and a q2.13 angle in radians
//   master channel returns real and imaginary parts in q1.14, saturated
// pipeline: 2 front-end stages + one stage per cordic rotation (16) + one
//   output stage between input transfer and output valid
// throughput: one transfer per cycle while the master side accepts, set by the
//   fully unrolled cordic where every rotation step has its own adder stage
// reset: rst_n clears every stage valid flag; the pipe comes up empty and
//   ready on the first cycle after release
// stall: each stage holds while the next one is full and stalled, so empty
//   stages keep filling behind a stalled output; tready on the slave side
//   drops only once all 19 stages hold data and tready on the master side is low
// ----------------------------------------------------------------------------
module complex_polar_to_rect_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // first_value [15:0], second_value [31:16]
    input  logic [0:0]  s_axis_tuser,   // form_is_rect [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // real_part [15:0], imag_part [31:16]
);
    import cp2r_pkg::*;

    // front end to cordic
    logic    prep_valid;
    logic    prep_ready;
    cordic_t prep_data;

    // cordic to output stage
    logic    rot_valid;
    logic    rot_ready;
    cordic_t rot_data;

    sample_t real_part;
    sample_t imag_part;

    cp2r_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_rect   (s_axis_tuser[0]),
        .in_a      (s_axis_tdata[15:0]),
        .in_b      (s_axis_tdata[31:16]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    cp2r_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    cp2r_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_real  (real_part),
        .out_imag  (imag_part)
    );

    assign m_axis_tdata = {imag_part, real_part};

    // residual angle bound after the last rotation, with margin
    localparam logic signed [Z_W-1:0] Z_RESID = Z_W'(ATAN_TAB[NUM_STEPS-1]) <<< 1;

    // input backpressure only comes from a full pipe behind a stalled output
    a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && rot_valid && prep_valid))
        else $error("slave tready low without a full stalled pipe");

    // an item waiting at the cordic input is not dropped
    a_prep_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (prep_valid && !prep_ready) |=> (prep_valid && $stable(prep_data)))
        else $error("front-end item lost while cordic stalled");

    // cordic must have driven the angle close to zero
    a_angle_converged : assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid |-> (rot_data.z <= Z_RESID && rot_data.z >= -Z_RESID))
        else $error("cordic residual angle out of range");

endmodule

// ----- dv/complex_polar_to_rect_checker.sv -----
// ----------------------------------------------------------------------------
// complex_polar_to_rect_checker
// watches both stream channels, predicts each result and compares it
// ----------------------------------------------------------------------------
module complex_polar_to_rect_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // first_value [15:0], second_value [31:16]
    input  logic [0:0]  s_axis_tuser,   // form_is_rect [0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // real_part [15:0], imag_part [31:16]
    output int          error_count,
    output int          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ATAN_LEN     = 24;
    localparam int     CORDIC_ITERS = (cp2r_pkg::ROTATION_STEPS < ATAN_LEN) ?
                                      cp2r_pkg::ROTATION_STEPS : ATAN_LEN;
    // angles and x/y in units of 2^-30
    localparam longint GAIN_COMP  = 64'sd652032874;
    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef struct {
        logic              is_rect;
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic signed [15:0] re;
        logic signed [15:0] im;
    } rect_t;

    rect_t awaited_rect_q[$];
    int    errors = 0;

    initial
    begin
        error_count = 0;
        outstanding = 0;
    end

    // atan(2^-i) in units of 2^-30 rad
    function automatic longint atan_q30(input int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic rect_t predict_rect(input logic is_rect,
                                           input logic signed [15:0] first,
                                           input logic signed [15:0] second);
        rect_t  r;
        longint x, y, z, nx, ny;
        bit     flip;
        r.is_rect = is_rect;
        r.first   = first;
        r.second  = second;
        if (is_rect)
        begin
            r.re = first;
            r.im = second;
            return r;
        end
        // q2.13 angle to 2^-30 units, one wrap into minus pi..pi
        z = longint'(second) * 131072;
        if (z > PI_Q30)
            z -= TWO_PI_Q30;
        else if (z < -PI_Q30)
            z += TWO_PI_Q30;
        // fold into the right half plane, negate the vector afterwards
        flip = 1'b0;
        if (z > HALF_PI_Q30)
        begin
            z -= PI_Q30;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z += PI_Q30;
            flip = 1'b1;
        end
        x = (longint'(first) * GAIN_COMP + 8192) >>> 14;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_q30(i);
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_q30(i);
            end
            x = nx;
            y = ny;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        r.re = clamp16((x + 32768) >>> 16);
        r.im = clamp16((y + 32768) >>> 16);
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        rect_t              want;
        logic signed [15:0] got_re;
        logic signed [15:0] got_im;
        int                 bad;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_rect_q.push_back(predict_rect(s_axis_tuser[0],
                                                      s_axis_tdata[15:0],
                                                      s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_re = m_axis_tdata[15:0];
                got_im = m_axis_tdata[31:16];
                if (awaited_rect_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("[%0t] unexpected result real %0d imag %0d",
                                 $realtime, got_re, got_im);
                    errors++;
                end
                else
                begin
                    want = awaited_rect_q.pop_front();
                    bad  = (got_re !== want.re) + (got_im !== want.im);
                    if (bad != 0)
                    begin
                        if (errors < 10)
                        begin
                            $write("[%0t] mismatch form %0d in %0d %0d: ",
                                   $realtime, want.is_rect, want.first, want.second);
                            $display("expected real %0d imag %0d, got real %0d imag %0d",
                                     want.re, want.im, got_re, got_im);
                        end
                        errors++;
                    end
                end
            end
            outstanding <= awaited_rect_q.size();
            error_count <= errors;
        end
    end

endmodule

// ----- dv/complex_polar_to_rect_unit_tb.sv -----
// ----------------------------------------------------------------------------
// complex_polar_to_rect_unit_tb
// drives polar and rectangular numbers into the converter under random
// backpressure and lets the checker compare every result with its prediction
// ----------------------------------------------------------------------------
module complex_polar_to_rect_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 300;
    // pipe is 19 deep; settle time after the last drain to show any stray output
    localparam int SETTLE_CYCLES    = 40;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // first_value [15:0], second_value [31:16]
    logic [0:0]  s_axis_tuser;   // form_is_rect [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // real_part [15:0], imag_part [31:16]

    int error_count;
    int outstanding;
    int src_idle_pct;
    int dst_idle_pct;

    complex_polar_to_rect_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    complex_polar_to_rect_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver side: ready drops at random, one decision per cycle
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // one input transfer; valid only drops when a gap is drawn, so a
    // back-to-back transfer never lowers and raises valid in one step
    task automatic send_number(input logic is_rect, input logic [15:0] first,
                               input logic [15:0] second);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {second, first};
        s_axis_tuser  <= is_rect;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop sending and wait for every predicted result to come back
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic send_directed();
        // rectangular pass-through at the field extremes and at small values
        send_number(1'b1, 16'h8000, 16'h7fff);
        send_number(1'b1, 16'h7fff, 16'h8000);
        send_number(1'b1, 16'h0000, 16'h0000);
        send_number(1'b1, 16'hffff, 16'h0001);
        // unit magnitude around the circle
        send_number(1'b0, 16'd16384, 16'd0);
        send_number(1'b0, 16'd16384, 16'd6434);        // pi/4
        send_number(1'b0, 16'd16384, 16'd12867);       // just below pi/2
        send_number(1'b0, 16'd16384, 16'd12868);       // just above pi/2, folded
        send_number(1'b0, 16'd16384, -16'sd12867);
        send_number(1'b0, 16'd16384, -16'sd12868);
        send_number(1'b0, 16'd16384, 16'd25735);       // just below pi
        send_number(1'b0, 16'd16384, 16'd25736);       // just above pi, wraps
        send_number(1'b0, 16'd16384, -16'sd25735);
        send_number(1'b0, 16'd16384, -16'sd25736);
        send_number(1'b0, 16'd16384, 16'h7fff);        // largest angle
        send_number(1'b0, 16'd16384, 16'h8000);        // most negative angle
        // magnitude extremes, saturation near two
        send_number(1'b0, 16'h7fff, 16'd0);
        send_number(1'b0, 16'h8000, 16'd0);
        send_number(1'b0, 16'h7fff, 16'd6434);
        send_number(1'b0, 16'h8000, -16'sd6434);
        send_number(1'b0, 16'h8000, 16'd25736);
        send_number(1'b0, 16'h7fff, 16'h8000);
        // negative magnitude and zero magnitude
        send_number(1'b0, -16'sd16384, 16'd4000);
        send_number(1'b0, 16'd0, 16'h7fff);
    endtask

    // mostly polar numbers; angles lean toward the fold and wrap edges
    task automatic send_random(input int count);
        logic        is_rect;
        logic [15:0] first;
        logic [15:0] second;
        for (int n = 0; n < count; n++)
        begin
            is_rect = ($urandom_range(3) == 0);
            first   = ($urandom_range(9) < 7) ? 16'($urandom) :
                      16'($signed($urandom_range(32768)) - 16384);
            case ($urandom_range(9))
                0:       second = 16'(12867 + $urandom_range(1));
                1:       second = 16'(-12868 + $urandom_range(1));
                2:       second = 16'(25735 + $urandom_range(1));
                3:       second = 16'(-25736 + $urandom_range(1));
                default: second = 16'($urandom);
            endcase
            send_number(is_rect, first, second);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        src_idle_pct  <= 15;
        dst_idle_pct  <= 50;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender idles a little, receiver stalls half the time
        send_directed();
        send_random(RANDOM_PER_PHASE);
        drain_pipe();

        // phase two: roles swapped
        src_idle_pct <= 50;
        dst_idle_pct <= 15;
        send_random(RANDOM_PER_PHASE);
        drain_pipe();

        // phase three: full rate both ways
        src_idle_pct <= 0;
        dst_idle_pct <= 0;
        send_random(RANDOM_PER_PHASE);
        drain_pipe();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
